FILE: sv/epat_pkg.sv
// ----------------------------------------------------------------------------
// Encoder angle tracker package
// Shared constants, codes and types of the angle tracker.
// ----------------------------------------------------------------------------
package epat_pkg;

    localparam int COUNT_BITS_DEF = 14;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int POS_W      = 48;
    localparam int ACC_W      = 32;
    localparam int VEL_W      = 32;
    localparam int INTERP_W   = 17;
    localparam int GAIN_W     = 24;
    localparam int PERIOD_W   = 16;
    localparam int POLE_W     = 6;
    localparam int ANGLE_W    = 14;
    localparam int ERRCNT_W   = 8;
    localparam int TURN_OUT_W = 30;
    localparam int PHASE_W    = 16;

    // Shared multiplier operand and product widths.
    localparam int MA_W   = 33;
    localparam int MB_W   = 25;
    localparam int PROD_W = MA_W + MB_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [ERRCNT_W-1:0] ERR_MAX     = 8'hFF;
    localparam logic [INTERP_W-1:0] INTERP_ONE  = 17'd65536;
    localparam logic [INTERP_W-1:0] INTERP_HALF = 17'd32768;
    localparam logic [PERIOD_W-1:0] TICK_RESET  = 16'd3277;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLE_PAIRS   = 3'd0,
        REG_ANGLE_OFFSET = 3'd1,
        REG_REVERSE      = 3'd2,
        REG_TICK_PERIOD  = 3'd3,
        REG_PROP_GAIN    = 3'd4,
        REG_INTEG_GAIN   = 3'd5,
        REG_ZERO_VEL     = 3'd6
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_STEP,
        ST_ERR,
        ST_MPOS,
        ST_APOS,
        ST_ATURN,
        ST_AVEL,
        ST_SNAP,
        ST_MINT,
        ST_AINT,
        ST_MPM,
        ST_MPI,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        MS_TICK_VEL,
        MS_PROP_DPOS,
        MS_PROP_DCPR,
        MS_INTEG_DCPR,
        MS_POLE_MECH,
        MS_POLE_INTERP
    } t_mul_sel;

    typedef struct packed {
        logic     in_ready;
        logic     out_load;
        t_mul_sel mul_sel;
        t_state   st;
    } t_ctrl;

endpackage

FILE: sv/epat_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, reused by every loop step.
// ----------------------------------------------------------------------------
module epat_mul (
    input  logic                                i_clk,
    input  logic signed [epat_pkg::MA_W-1:0]    i_a,
    input  logic signed [epat_pkg::MB_W-1:0]    i_b,
    output logic signed [epat_pkg::PROD_W-1:0]  o_prod
);

    logic signed [epat_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: sv/epat_ctrl.sv
// ----------------------------------------------------------------------------
// Tracker sequencer
// Steps one item through the loop update, one shared multiply per step.
// ----------------------------------------------------------------------------
module epat_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_free,
    output epat_pkg::t_ctrl o_ctrl
);

    epat_pkg::t_state r_state;
    epat_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= epat_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            epat_pkg::ST_IDLE:  if (i_in_valid) n_state = epat_pkg::ST_PRED;
            epat_pkg::ST_PRED:  n_state = epat_pkg::ST_STEP;
            epat_pkg::ST_STEP:  n_state = epat_pkg::ST_ERR;
            epat_pkg::ST_ERR:   n_state = epat_pkg::ST_MPOS;
            epat_pkg::ST_MPOS:  n_state = epat_pkg::ST_APOS;
            epat_pkg::ST_APOS:  n_state = epat_pkg::ST_ATURN;
            epat_pkg::ST_ATURN: n_state = epat_pkg::ST_AVEL;
            epat_pkg::ST_AVEL:  n_state = epat_pkg::ST_SNAP;
            epat_pkg::ST_SNAP:  n_state = epat_pkg::ST_MINT;
            epat_pkg::ST_MINT:  n_state = epat_pkg::ST_AINT;
            epat_pkg::ST_AINT:  n_state = epat_pkg::ST_MPM;
            epat_pkg::ST_MPM:   n_state = epat_pkg::ST_MPI;
            epat_pkg::ST_MPI:   n_state = epat_pkg::ST_OUT;
            epat_pkg::ST_OUT:   if (i_out_free) n_state = epat_pkg::ST_IDLE;
            default:            n_state = epat_pkg::ST_IDLE;
        endcase
    end

    // The phase product must stay put while the result waits for the
    // output register, so its operands are held through the last step.
    always_comb begin
        o_ctrl.st       = r_state;
        o_ctrl.in_ready = (r_state == epat_pkg::ST_IDLE);
        o_ctrl.out_load = (r_state == epat_pkg::ST_OUT) && i_out_free;
        unique case (r_state) inside
            epat_pkg::ST_MPOS:  o_ctrl.mul_sel = epat_pkg::MS_PROP_DPOS;
            epat_pkg::ST_APOS:  o_ctrl.mul_sel = epat_pkg::MS_PROP_DCPR;
            epat_pkg::ST_ATURN: o_ctrl.mul_sel = epat_pkg::MS_INTEG_DCPR;
            epat_pkg::ST_MPM:   o_ctrl.mul_sel = epat_pkg::MS_POLE_MECH;
            epat_pkg::ST_MPI, epat_pkg::ST_OUT:
                                o_ctrl.mul_sel = epat_pkg::MS_POLE_INTERP;
            default:            o_ctrl.mul_sel = epat_pkg::MS_TICK_VEL;
        endcase
    end

endmodule

FILE: sv/encoder_pll_angle_tracker.sv
// ----------------------------------------------------------------------------
// Encoder angle tracker
// Sensor frame decode, tracking loop for position and velocity, angle output.
// ----------------------------------------------------------------------------
// Each item is one 24-bit sensor frame with its transfer-ok flag; it produces
// one result item with error counters, the tracked multi-turn position, the
// position within one turn, the velocity, the edge interpolation fraction and
// the mechanical and electrical angles. The loop update runs as a chain of
// steps on a single shared 33 by 25 bit multiplier, and the next item is
// taken only once that chain is done and its result is loaded into the
// output register, so items do not overlap in the loop. The input side
// accepts an item only while the sequencer is idle, but a finished result
// sits in an output register, so the next item may be taken while the
// previous result still waits to be read. If that next result is also done
// before the first one is read, the sequencer waits in its last step and
// the input stays closed. Registers are written through the configuration
// channel, which is always ready, and should be written only while no item
// is in flight.
// ----------------------------------------------------------------------------
module encoder_pll_angle_tracker #(
    parameter int COUNT_BITS = epat_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = epat_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [epat_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [epat_pkg::CFG_DATA_W-1:0]       i_cfg_data,

    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [23:0]                           i_spi_frame,
    input  logic                                  i_transfer_ok,

    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_sample_valid,
    output logic [1:0]                            o_magnet_status,
    output logic [epat_pkg::ERRCNT_W-1:0]         o_transfer_errors,
    output logic [epat_pkg::ERRCNT_W-1:0]         o_magnet_errors,
    output logic signed [epat_pkg::POS_W-1:0]     o_multi_turn_position,
    output logic [epat_pkg::TURN_OUT_W-1:0]       o_turn_position,
    output logic signed [epat_pkg::VEL_W-1:0]     o_velocity_estimate,
    output logic [epat_pkg::INTERP_W-1:0]         o_interp_fraction,
    output logic signed [epat_pkg::PHASE_W-1:0]   o_elec_phase,
    output logic [epat_pkg::ANGLE_W-1:0]          o_mech_angle,
    output logic [epat_pkg::ANGLE_W-1:0]          o_elec_count
);

    localparam int C       = COUNT_BITS;
    localparam int TURN_W  = COUNT_BITS + FRAC_BITS;
    localparam int STEP_SH = 24 - FRAC_BITS;
    localparam int UP_SH   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DN_SH   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int PM_W    = COUNT_BITS + epat_pkg::POLE_W;
    localparam int PI_W    = epat_pkg::INTERP_W + epat_pkg::POLE_W;
    localparam int PH_W    = COUNT_BITS + 16;
    localparam int PW      = epat_pkg::PROD_W;
    localparam logic [C-1:0] HALF_CPR = C'(1) << (C - 1);
    localparam logic signed [PW-1:0] VMAX = {{(PW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [PW-1:0] VMIN = {{(PW-31){1'b1}}, {31{1'b0}}};

    // Configuration registers.
    logic [epat_pkg::POLE_W-1:0]   r_pole;
    logic [epat_pkg::ANGLE_W-1:0]  r_offset;
    logic                          r_reverse;
    logic [epat_pkg::PERIOD_W-1:0] r_tick;
    logic [epat_pkg::PERIOD_W-1:0] r_prop;
    logic [epat_pkg::GAIN_W-1:0]   r_integ;
    logic [epat_pkg::GAIN_W-1:0]   r_zvel;

    // Tracker state.
    logic [C-1:0]                   r_held;
    logic [C-1:0]                   r_prev;
    logic [epat_pkg::ACC_W-1:0]     r_acc;
    logic [epat_pkg::POS_W-1:0]     r_pos;
    logic [TURN_W-1:0]              r_turn;
    logic signed [epat_pkg::VEL_W-1:0] r_vel;
    logic [epat_pkg::INTERP_W-1:0]  r_interp;
    logic [1:0]                     r_mstat;
    logic [epat_pkg::ERRCNT_W-1:0]  r_terr;
    logic [epat_pkg::ERRCNT_W-1:0]  r_merr;

    // Per-item working registers.
    logic                           r_sv;
    logic                           r_dlt_pos;
    logic                           r_dlt_neg;
    logic signed [epat_pkg::ACC_W-1:0] r_dpos;
    logic signed [C-1:0]            r_dcpr;
    logic                           r_snap;
    logic [C-1:0]                   r_mech;
    logic [PM_W-1:0]                r_pm;
    logic                           r_out_valid;

    epat_pkg::t_ctrl                ctrl;
    logic signed [epat_pkg::MA_W-1:0] mul_a;
    logic signed [epat_pkg::MB_W-1:0] mul_b;
    logic signed [PW-1:0]           prod;

    // Frame decode and wrapped delta at acceptance.
    logic                           in_acc;
    logic [15:0]                    angle16;
    logic [C-1:0]                   angle;
    logic [1:0]                     fstat;
    logic                           good;
    logic [C-1:0]                   n_held;
    logic [C-1:0]                   diff;
    logic [C:0]                     dlt;

    // Datapath intermediates.
    logic signed [PW-1:0]           step;
    logic signed [PW-1:0]           tfrac;
    logic signed [epat_pkg::POS_W-1:0] pint;
    logic signed [PW-1:0]           vsum;
    logic signed [epat_pkg::VEL_W-1:0] vsat;
    logic [epat_pkg::VEL_W:0]       vabs;
    logic signed [PW-1:0]           isum;
    logic [15:0]                    off16;
    logic [PH_W-1:0]                ph_sum;
    logic                           out_free;

    assign in_acc   = i_in_valid && ctrl.in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign angle16 = {2'b00, i_spi_frame[23:10]};
    assign angle   = angle16[C-1:0];
    assign fstat   = i_spi_frame[7:6];
    assign good    = i_transfer_ok && (fstat == 2'b00);
    assign n_held  = !good ? r_held : (r_reverse ? (C'(0) - angle) : angle);
    assign diff    = n_held - r_prev;
    // Delta lies in (-CPR/2, CPR/2]: a difference of exactly half a turn is forward.
    assign dlt     = {1'b0, diff} - ((diff > HALF_CPR) ? {1'b1, {C{1'b0}}} : '0);

    assign step  = prod >>> STEP_SH;
    assign tfrac = (FRAC_BITS >= 16) ? (prod <<< UP_SH) : (prod >>> DN_SH);
    assign pint  = $signed(r_pos) >>> FRAC_BITS;
    assign vsum  = PW'(r_vel) + prod;
    assign vsat  = (vsum > VMAX) ? epat_pkg::VEL_W'(VMAX) :
                   (vsum < VMIN) ? epat_pkg::VEL_W'(VMIN) : epat_pkg::VEL_W'(vsum);
    assign vabs  = r_vel[epat_pkg::VEL_W-1] ? -{r_vel[epat_pkg::VEL_W-1], r_vel}
                                            : {1'b0, r_vel};
    // Both terms stay signed so the shift keeps the sign of the product.
    assign isum  = (prod >>> 8) + $signed(PW'(r_interp));
    assign off16 = {2'b00, r_offset};
    assign ph_sum = PH_W'({r_pm, 16'd0}) + PH_W'(prod[PI_W-1:0]);

    epat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul_sel)
            epat_pkg::MS_TICK_VEL: begin
                mul_a = epat_pkg::MA_W'(r_vel);
                mul_b = epat_pkg::MB_W'(r_tick);
            end
            epat_pkg::MS_PROP_DPOS: begin
                mul_a = epat_pkg::MA_W'(r_dpos);
                mul_b = epat_pkg::MB_W'(r_prop);
            end
            epat_pkg::MS_PROP_DCPR: begin
                mul_a = epat_pkg::MA_W'(r_dcpr);
                mul_b = epat_pkg::MB_W'(r_prop);
            end
            epat_pkg::MS_INTEG_DCPR: begin
                mul_a = epat_pkg::MA_W'(r_dcpr);
                mul_b = epat_pkg::MB_W'(r_integ);
            end
            epat_pkg::MS_POLE_MECH: begin
                mul_a = epat_pkg::MA_W'(r_mech);
                mul_b = epat_pkg::MB_W'(r_pole);
            end
            epat_pkg::MS_POLE_INTERP: begin
                mul_a = epat_pkg::MA_W'(r_interp);
                mul_b = epat_pkg::MB_W'(r_pole);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    epat_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Configuration writes.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole    <= '0;
            r_offset  <= '0;
            r_reverse <= 1'b0;
            r_tick    <= epat_pkg::TICK_RESET;
            r_prop    <= '0;
            r_integ   <= '0;
            r_zvel    <= '0;
        end else if (i_cfg_valid) begin
            unique case (epat_pkg::t_cfg_reg'(i_cfg_index))
                epat_pkg::REG_POLE_PAIRS:   r_pole    <= i_cfg_data[epat_pkg::POLE_W-1:0];
                epat_pkg::REG_ANGLE_OFFSET: r_offset  <= i_cfg_data[epat_pkg::ANGLE_W-1:0];
                epat_pkg::REG_REVERSE:      r_reverse <= i_cfg_data[0];
                epat_pkg::REG_TICK_PERIOD:  r_tick    <= i_cfg_data[epat_pkg::PERIOD_W-1:0];
                epat_pkg::REG_PROP_GAIN:    r_prop    <= i_cfg_data[epat_pkg::PERIOD_W-1:0];
                epat_pkg::REG_INTEG_GAIN:   r_integ   <= i_cfg_data;
                epat_pkg::REG_ZERO_VEL:     r_zvel    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Loop state, updated one step per sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_prev   <= '0;
            r_acc    <= '0;
            r_pos    <= '0;
            r_turn   <= '0;
            r_vel    <= '0;
            r_interp <= '0;
            r_mstat  <= '0;
            r_terr   <= '0;
            r_merr   <= '0;
        end else begin
            if (in_acc) begin
                // A failed transfer keeps the held count and the magnet status.
                if (!i_transfer_ok) begin
                    if (r_terr != epat_pkg::ERR_MAX) r_terr <= r_terr + 1'b1;
                end else begin
                    r_mstat <= fstat;
                    if (fstat != 2'b00 && r_merr != epat_pkg::ERR_MAX) begin
                        r_merr <= r_merr + 1'b1;
                    end
                end
                r_held <= n_held;
                r_prev <= n_held;
                r_acc  <= r_acc + epat_pkg::ACC_W'($signed(dlt));
            end
            case (ctrl.st)
                epat_pkg::ST_STEP: begin
                    r_pos  <= r_pos + step[epat_pkg::POS_W-1:0];
                    r_turn <= r_turn + step[TURN_W-1:0];
                end
                epat_pkg::ST_APOS:  r_pos  <= r_pos + tfrac[epat_pkg::POS_W-1:0];
                epat_pkg::ST_ATURN: r_turn <= r_turn + tfrac[TURN_W-1:0];
                epat_pkg::ST_AVEL:  r_vel  <= vsat;
                epat_pkg::ST_SNAP: begin
                    if (vabs < (epat_pkg::VEL_W+1)'(r_zvel)) r_vel <= '0;
                end
                epat_pkg::ST_AINT: begin
                    // Snap wins, then a count edge, else integrate and clamp to [0, 1].
                    if (r_snap) begin
                        r_interp <= epat_pkg::INTERP_HALF;
                    end else if (r_dlt_pos) begin
                        r_interp <= '0;
                    end else if (r_dlt_neg) begin
                        r_interp <= epat_pkg::INTERP_ONE;
                    end else if (isum > $signed(PW'(epat_pkg::INTERP_ONE))) begin
                        r_interp <= epat_pkg::INTERP_ONE;
                    end else if (isum < 0) begin
                        r_interp <= '0;
                    end else begin
                        r_interp <= epat_pkg::INTERP_W'(isum);
                    end
                end
                default: ;
            endcase
        end
    end

    // Per-item working values.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sv      <= good;
            r_dlt_pos <= !dlt[C] && (dlt != '0);
            r_dlt_neg <= dlt[C];
        end
        case (ctrl.st)
            epat_pkg::ST_ERR: begin
                r_dpos <= r_acc - pint[epat_pkg::ACC_W-1:0];
                r_dcpr <= r_prev - r_turn[TURN_W-1:FRAC_BITS];
            end
            epat_pkg::ST_SNAP: r_snap <= (vabs < (epat_pkg::VEL_W+1)'(r_zvel));
            epat_pkg::ST_AINT: r_mech <= r_prev - off16[C-1:0];
            epat_pkg::ST_MPI:  r_pm   <= prod[PM_W-1:0];
            default: ;
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            o_sample_valid        <= r_sv;
            o_magnet_status       <= r_mstat;
            o_transfer_errors     <= r_terr;
            o_magnet_errors       <= r_merr;
            o_multi_turn_position <= r_pos;
            o_turn_position       <= epat_pkg::TURN_OUT_W'(r_turn);
            o_velocity_estimate   <= r_vel;
            o_interp_fraction     <= r_interp;
            o_elec_phase          <= ph_sum[PH_W-1:C];
            o_mech_angle          <= epat_pkg::ANGLE_W'(r_mech);
            o_elec_count          <= epat_pkg::ANGLE_W'(r_pm[C-1:0]);
        end
    end

    assign o_in_ready  = ctrl.in_ready;
    assign o_out_valid = r_out_valid;

    // The interpolation fraction never leaves [0, 1].
    a_interp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_interp <= epat_pkg::INTERP_ONE)
        else $error("interpolation fraction out of range");

    // An accepted item keeps the input closed on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input ready while an item is in flight");

    // A result load always presents a result on the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.out_load |=> o_out_valid)
        else $error("loaded result not presented");

    // A snapped velocity leaves the velocity state at zero.
    a_snap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.st == epat_pkg::ST_AINT) && r_snap |-> (r_vel == '0))
        else $error("snapped velocity is not zero");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Angle tracker testbench
// Drives sensor frames through the valid/ready input channel. Each result item
// is checked against a behavioral model of the tracking loop that runs inside
// this bench, or against a hand-typed table row where one is given. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CPR      = 1 << epat_pkg::COUNT_BITS_DEF;
    localparam int HALF_CPR = CPR / 2;
    localparam int FRAC     = epat_pkg::FRAC_BITS_DEF;
    localparam int LATENCY  = 14;
    localparam int N_RAND   = 820;

    // Expected contents of one result item.
    typedef struct packed {
        logic                                sample_valid;
        logic [1:0]                          magnet_status;
        logic [7:0]                          transfer_errors;
        logic [7:0]                          magnet_errors;
        logic [epat_pkg::POS_W-1:0]          multi_turn_position;
        logic [epat_pkg::TURN_OUT_W-1:0]     turn_position;
        logic [epat_pkg::VEL_W-1:0]          velocity_estimate;
        logic [epat_pkg::INTERP_W-1:0]       interp_fraction;
        logic [epat_pkg::PHASE_W-1:0]        elec_phase;
        logic [epat_pkg::ANGLE_W-1:0]        mech_angle;
        logic [epat_pkg::ANGLE_W-1:0]        elec_count;
    } t_tracker_result;

    // One row of the directed table. A row with has_exp set also carries a
    // result that can be read off the behavior by eye.
    typedef struct {
        logic [23:0]     frame;
        logic            ok;
        logic            has_exp;
        t_tracker_result exp;
    } t_frame_row;

    logic i_clk, i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [epat_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [epat_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic i_in_valid, o_in_ready;
    logic [23:0] i_spi_frame;
    logic i_transfer_ok;
    logic o_out_valid, i_out_ready;
    logic o_sample_valid;
    logic [1:0] o_magnet_status;
    logic [7:0] o_transfer_errors, o_magnet_errors;
    logic signed [epat_pkg::POS_W-1:0] o_multi_turn_position;
    logic [epat_pkg::TURN_OUT_W-1:0] o_turn_position;
    logic signed [epat_pkg::VEL_W-1:0] o_velocity_estimate;
    logic [epat_pkg::INTERP_W-1:0] o_interp_fraction;
    logic signed [epat_pkg::PHASE_W-1:0] o_elec_phase;
    logic [epat_pkg::ANGLE_W-1:0] o_mech_angle, o_elec_count;

    encoder_pll_angle_tracker dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Model copy of the configuration registers.
    logic [5:0]  m_pole_pairs;
    logic [13:0] m_angle_offset;
    logic        m_reverse;
    logic [15:0] m_tick_period;
    logic [15:0] m_prop_gain;
    logic [23:0] m_integ_gain;
    logic [23:0] m_zero_vel;

    // Model copy of the tracker state.
    logic [13:0] m_held, m_prev;
    logic [31:0] m_acc_count;
    logic [47:0] m_pos;
    logic [29:0] m_turn;
    longint      m_vel, m_interp;
    logic [1:0]  m_mag_status;
    logic [7:0]  m_xfer_errs, m_mag_errs;

    t_tracker_result expected_results[$];
    int  n_mismatch, n_checked, n_sent, n_snaps, n_faults;
    logic hold_off;

    function automatic void reset_tracker_model();
        m_pole_pairs = '0; m_angle_offset = '0; m_reverse = 1'b0;
        m_tick_period = epat_pkg::TICK_RESET; m_prop_gain = '0; m_integ_gain = '0;
        m_zero_vel = '0;
        m_held = '0; m_prev = '0; m_acc_count = '0; m_pos = '0; m_turn = '0;
        m_vel = 0; m_interp = 0; m_mag_status = '0;
        m_xfer_errs = '0; m_mag_errs = '0;
    endfunction

    // Advance the loop model by one frame and return the result it gives.
    // The >>> on a longint is an arithmetic shift, that is a floor divide.
    function automatic t_tracker_result track_frame(logic [23:0] frame, logic ok);
        t_tracker_result r;
        longint delta, step, dpos, dcpr, vel, mag, pint;
        logic [31:0] d32;
        logic [13:0] mech, elec, angle;
        logic [63:0] phase_x;
        bit valid, snap;
        valid = 0;
        snap = 0;
        if (!ok) begin
            if (m_xfer_errs != epat_pkg::ERR_MAX) m_xfer_errs++;
        end else begin
            m_mag_status = frame[7:6];
            if (m_mag_status != 0) begin
                if (m_mag_errs != epat_pkg::ERR_MAX) m_mag_errs++;
            end else begin
                angle = frame[23:10];
                m_held = m_reverse ? 14'(CPR - angle) : angle;
                valid = 1;
            end
        end
        delta = longint'(14'(m_held - m_prev));
        if (delta > HALF_CPR) delta -= CPR;
        m_acc_count = m_acc_count + 32'(delta);
        m_prev = m_held;
        step = (longint'(m_tick_period) * m_vel) >>> (24 - FRAC);
        m_pos = m_pos + 48'(step);
        m_turn = m_turn + 30'(step);
        pint = longint'($signed(m_pos)) >>> FRAC;
        d32 = m_acc_count - 32'(pint);
        dpos = longint'($signed(d32));
        dcpr = longint'(m_prev) - longint'(m_turn >> FRAC);
        if (dcpr >= HALF_CPR) dcpr -= CPR;
        if (dcpr < -HALF_CPR) dcpr += CPR;
        m_pos = m_pos + 48'(longint'(m_prop_gain) * dpos);
        m_turn = m_turn + 30'(longint'(m_prop_gain) * dcpr);
        vel = m_vel + longint'(m_integ_gain) * dcpr;
        if (vel > 64'sd2147483647) vel = 64'sd2147483647;
        if (vel < -64'sd2147483648) vel = -64'sd2147483648;
        mag = vel < 0 ? -vel : vel;
        if (mag < longint'(m_zero_vel)) begin
            vel = 0;
            snap = 1;
        end
        m_vel = vel;
        if (snap) m_interp = 32768;
        else if (delta > 0) m_interp = 0;
        else if (delta < 0) m_interp = 65536;
        else begin
            m_interp += (longint'(m_tick_period) * m_vel) >>> 8;
            if (m_interp > 65536) m_interp = 65536;
            if (m_interp < 0) m_interp = 0;
        end
        if (snap) n_snaps++;
        mech = m_prev - m_angle_offset;
        elec = 14'(m_pole_pairs * mech);
        phase_x = 64'(m_pole_pairs) * ((64'(mech) << 16) + 64'(m_interp));
        phase_x = (phase_x & ((64'd1 << (epat_pkg::COUNT_BITS_DEF + 16)) - 1))
                  >> epat_pkg::COUNT_BITS_DEF;
        r.sample_valid = valid;
        r.magnet_status = m_mag_status;
        r.transfer_errors = m_xfer_errs;
        r.magnet_errors = m_mag_errs;
        r.multi_turn_position = m_pos;
        r.turn_position = m_turn;
        r.velocity_estimate = 32'(m_vel);
        r.interp_fraction = 17'(m_interp);
        r.elec_phase = phase_x[15:0];
        r.mech_angle = mech;
        r.elec_count = elec;
        return r;
    endfunction

    // Frame builder: 14-bit angle in bits 23..10, magnet status in bits 7..6,
    // filler bits everywhere else.
    function automatic logic [23:0] make_frame(logic [13:0] angle, logic [1:0] status,
                                               logic [7:0] junk);
        return {angle, junk[1:0], status, junk[7:2]};
    endfunction

    task automatic write_reg(epat_pkg::t_cfg_reg idx, logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            epat_pkg::REG_POLE_PAIRS:   m_pole_pairs   = data[5:0];
            epat_pkg::REG_ANGLE_OFFSET: m_angle_offset = data[13:0];
            epat_pkg::REG_REVERSE:      m_reverse      = data[0];
            epat_pkg::REG_TICK_PERIOD:  m_tick_period  = data[15:0];
            epat_pkg::REG_PROP_GAIN:    m_prop_gain    = data[15:0];
            epat_pkg::REG_INTEG_GAIN:   m_integ_gain   = data;
            default:                    m_zero_vel     = data;
        endcase
    endtask

    // Offer one frame, predicting its result at the moment it is accepted.
    // Valid stays high across back-to-back items, so it is only lowered when
    // an idle gap follows.
    task automatic send_frame(logic [23:0] frame, logic ok, int gap,
                              bit has_exp, t_tracker_result exp);
        t_tracker_result pred;
        i_in_valid <= 1'b1;
        i_spi_frame <= frame;
        i_transfer_ok <= ok;
        do @(posedge i_clk); while (!o_in_ready);
        pred = track_frame(frame, ok);
        if (has_exp && pred !== exp)
            $display("note: hand-typed row differs from model, frame %h", frame);
        expected_results.push_back(has_exp ? exp : pred);
        n_sent++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Let the block go quiet before touching registers. Every item gives a
    // result, so an empty queue plus the pipeline latency is enough.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    endfunction

    // Random frames: mostly healthy with a slowly moving angle so the loop
    // can track, the rest failed transfers, magnet faults and wild jumps.
    task automatic random_phase(int count, bit bursty);
        t_tracker_result none;
        logic [13:0] angle;
        int kind, gap;
        none = '0;
        angle = 14'($urandom);
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(0, 19);
            if (kind < 14) angle = angle + 14'($urandom_range(0, 80) - 40);
            else if (kind < 16) angle = 14'($urandom);
            gap = bursty ? 0 : draw_gap();
            if (kind == 16) begin
                send_frame(24'($urandom), 1'b0, gap, 0, none);
            end else if (kind == 17) begin
                n_faults++;
                send_frame(make_frame(angle, 2'($urandom_range(1, 3)), 8'($urandom)),
                           1'b1, gap, 0, none);
            end else begin
                send_frame(make_frame(angle, 2'b00, 8'($urandom)), 1'b1, gap, 0, none);
            end
        end
    endtask

    // Reader side: it compares each accepted result with the oldest
    // expectation, and stalls at random or for as long as a hold-off lasts.
    initial begin
        t_tracker_result exp, got;
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (stall > 0 || hold_off) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            got = {o_sample_valid, o_magnet_status, o_transfer_errors, o_magnet_errors,
                   o_multi_turn_position, o_turn_position, o_velocity_estimate,
                   o_interp_fraction, o_elec_phase, o_mech_angle, o_elec_count};
            if (expected_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("ERROR: result item with none expected");
            end else begin
                exp = expected_results.pop_front();
                n_checked++;
                if (got !== exp) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("ERROR: item %0d mismatch", n_checked);
                        $display("  valid/stat/terr/merr exp %b %0d %0d %0d got %b %0d %0d %0d",
                                 exp.sample_valid, exp.magnet_status, exp.transfer_errors,
                                 exp.magnet_errors, got.sample_valid, got.magnet_status,
                                 got.transfer_errors, got.magnet_errors);
                        $display("  pos %h/%h turn %h/%h vel %h/%h",
                                 exp.multi_turn_position, got.multi_turn_position,
                                 exp.turn_position, got.turn_position,
                                 exp.velocity_estimate, got.velocity_estimate);
                        $display("  interp %h/%h phase %h/%h mech %h/%h elec %h/%h",
                                 exp.interp_fraction, got.interp_fraction,
                                 exp.elec_phase, got.elec_phase, exp.mech_angle,
                                 got.mech_angle, exp.elec_count, got.elec_count);
                    end
                end
            end
        end
    end

    // Long reader stall, counted here, while the sender keeps offering items
    // back to back in the snap phase.
    initial begin
        hold_off = 1'b0;
        wait (n_sent >= 960);
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Hard ceiling: ~1350 items with the longest sender gaps and reader stalls, many times over.
    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_frame_row rows[$];
        t_frame_row row;
        t_tracker_result none;
        none = '0;
        n_mismatch = 0; n_checked = 0; n_sent = 0; n_snaps = 0; n_faults = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_spi_frame = '0; i_transfer_ok = 1'b0;
        reset_tracker_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames at reset gains. With zero gains nothing moves in
        // the loop, so the first rows can be typed in by hand.
        row.frame = 24'h000000; row.ok = 1'b1; row.has_exp = 1;
        row.exp = none; row.exp.sample_valid = 1; row.exp.interp_fraction = 17'(0);
        rows.push_back(row);
        // A failed transfer only bumps its counter.
        row.frame = 24'hFFFFFF; row.ok = 1'b0;
        row.exp.sample_valid = 0; row.exp.transfer_errors = 8'd1;
        rows.push_back(row);
        row.has_exp = 0;
        // Largest angle with each nonzero magnet status, then healthy.
        row.ok = 1'b1;
        row.frame = make_frame(14'h3FFF, 2'b01, 8'hFF); rows.push_back(row);
        row.frame = make_frame(14'h3FFF, 2'b10, 8'h00); rows.push_back(row);
        row.frame = make_frame(14'h3FFF, 2'b11, 8'hAA); rows.push_back(row);
        row.frame = make_frame(14'h3FFF, 2'b00, 8'hFF); rows.push_back(row);
        // Delta of exactly half a turn, both directions, and small steps.
        row.frame = make_frame(14'h1FFF, 2'b00, 8'h55); rows.push_back(row);
        row.frame = make_frame(14'h3FFF, 2'b00, 8'h00); rows.push_back(row);
        row.frame = make_frame(14'h0000, 2'b00, 8'h00); rows.push_back(row);
        row.frame = make_frame(14'h2000, 2'b00, 8'h00); rows.push_back(row);
        row.frame = make_frame(14'h2001, 2'b00, 8'h00); rows.push_back(row);
        row.frame = make_frame(14'h2001, 2'b00, 8'h00); rows.push_back(row);
        for (int k = 0; k < rows.size(); k++)
            send_frame(rows[k].frame, rows[k].ok, k % 3, rows[k].has_exp, rows[k].exp);
        drain();

        // Saturate both error counters, then hold them at the top.
        for (int k = 0; k < 258; k++) send_frame(24'($urandom), 1'b0, 0, 0, none);
        for (int k = 0; k < 258; k++)
            send_frame(make_frame(14'($urandom), 2'b11, 8'($urandom)), 1'b1, 0, 0, none);
        drain();

        // Phase: moderate loop gains, forward direction.
        write_reg(epat_pkg::REG_POLE_PAIRS, 24'd7);
        write_reg(epat_pkg::REG_ANGLE_OFFSET, 24'd1234);
        write_reg(epat_pkg::REG_REVERSE, 24'd0);
        write_reg(epat_pkg::REG_TICK_PERIOD, 24'd3277);
        write_reg(epat_pkg::REG_PROP_GAIN, 24'd20000);
        write_reg(epat_pkg::REG_INTEG_GAIN, 24'd40000);
        write_reg(epat_pkg::REG_ZERO_VEL, 24'd256);
        random_phase(N_RAND / 4, 0);
        drain();

        // Phase: every register but the snap threshold at its top, reversed direction. The velocity
        // saturates and the position races around.
        write_reg(epat_pkg::REG_POLE_PAIRS, 24'd63);
        write_reg(epat_pkg::REG_ANGLE_OFFSET, 24'h3FFF);
        write_reg(epat_pkg::REG_REVERSE, 24'd1);
        write_reg(epat_pkg::REG_TICK_PERIOD, 24'hFFFF);
        write_reg(epat_pkg::REG_PROP_GAIN, 24'hFFFF);
        write_reg(epat_pkg::REG_INTEG_GAIN, 24'hFFFFFF);
        write_reg(epat_pkg::REG_ZERO_VEL, 24'd0);
        random_phase(N_RAND / 4, 0);
        drain();

        // Phase: high snap threshold so velocity mostly snaps to zero; this
        // one is sent back to back and carries the long reader stall.
        write_reg(epat_pkg::REG_POLE_PAIRS, 24'd0);
        write_reg(epat_pkg::REG_ANGLE_OFFSET, 24'd0);
        write_reg(epat_pkg::REG_TICK_PERIOD, 24'd0);
        write_reg(epat_pkg::REG_PROP_GAIN, 24'd1);
        write_reg(epat_pkg::REG_INTEG_GAIN, 24'd1000);
        write_reg(epat_pkg::REG_ZERO_VEL, 24'hFFFFFF);
        random_phase(N_RAND / 4, 1);
        drain();

        // Phase: random register values.
        write_reg(epat_pkg::REG_POLE_PAIRS, 24'($urandom_range(1, 63)));
        write_reg(epat_pkg::REG_ANGLE_OFFSET, 24'($urandom_range(0, 16383)));
        write_reg(epat_pkg::REG_REVERSE, 24'($urandom_range(0, 1)));
        write_reg(epat_pkg::REG_TICK_PERIOD, 24'($urandom_range(0, 65535)));
        write_reg(epat_pkg::REG_PROP_GAIN, 24'($urandom_range(0, 65535)));
        write_reg(epat_pkg::REG_INTEG_GAIN, 24'($urandom_range(0, 200000)));
        write_reg(epat_pkg::REG_ZERO_VEL, 24'($urandom_range(0, 5000)));
        random_phase(N_RAND - 3 * (N_RAND / 4), 0);

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("Covered %0d frames (%0d checked), %0d magnet faults, %0d velocity snaps,",
                 n_sent, n_checked, n_faults, n_snaps);
        $display("error counter saturation and five register settings including extremes.");
        if (n_mismatch == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
